// ===== hdl/mbf_pkg.sv =====
`timescale 1ns / 1ps

package mbf_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int MAX_LEVELS_DEF = 11;

   localparam int NUM_CH  = 4;
   localparam int CH_W    = 8;
   localparam int PAIR_W  = 9;   // sum of two pixels
   localparam int BLOCK_W = 10;  // sum of up to four pixels

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;
   localparam logic [10:0]     WIDTH_RST    = 11'd1024;
   localparam logic [10:0]     HEIGHT_RST   = 11'd1024;
   localparam logic [3:0]      LEVELS_RST   = 4'd11;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH   = 8'd0,
      CSR_IMAGE_HEIGHT  = 8'd1,
      CSR_LEVEL_COUNT   = 8'd2,
      CSR_THREE_CHANNEL = 8'd3
   } csr_index_type;

   typedef enum logic {
      SEQ_IDLE = 1'b0,
      SEQ_EXEC = 1'b1
   } seq_state_type;

   // channel order: red, green, blue, alpha
   typedef logic [NUM_CH-1:0][CH_W-1:0]    pixel_type;
   typedef logic [NUM_CH-1:0][PAIR_W-1:0]  pair_type;
   typedef logic [NUM_CH-1:0][BLOCK_W-1:0] block_type;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] alpha_in;
   } req_type;

   typedef struct packed {
      logic [3:0] level;
      logic [9:0] col;
      logic [9:0] row;
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [7:0] alpha_out;
      logic       last_of_item;
      logic       image_done;
   } rsp_type;

   typedef struct packed {
      logic [10:0] image_width;
      logic [10:0] image_height;
      logic [3:0]  level_count;
      logic        three_channel_mode;
      logic        restart;
   } cfg_type;

endpackage

// ===== hdl/mbf_cfg.sv =====
`timescale 1ns / 1ps

module mbf_cfg (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mbf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mbf_pkg::CSR_DATA_W-1:0]     csr_data,
   output mbf_pkg::cfg_type                   cfg
);

   logic [10:0] width_ff, width_in;
   logic [10:0] height_ff, height_in;
   logic [3:0]  levels_ff, levels_in;
   logic        three_ch_ff, three_ch_in;
   logic        wr;
   logic        restart;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      levels_in   = levels_ff;
      three_ch_in = three_ch_ff;
      restart     = 1'b0;
      if (wr) begin
         unique case (csr_index)
            mbf_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_data[10:0];
               restart  = 1'b1;
            end
            mbf_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_data[10:0];
               restart   = 1'b1;
            end
            mbf_pkg::CSR_LEVEL_COUNT: begin
               levels_in = csr_data[3:0];
               restart   = 1'b1;
            end
            mbf_pkg::CSR_THREE_CHANNEL: begin
               three_ch_in = csr_data[0];
               restart     = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= mbf_pkg::WIDTH_RST;
         height_ff   <= mbf_pkg::HEIGHT_RST;
         levels_ff   <= mbf_pkg::LEVELS_RST;
         three_ch_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         levels_ff   <= levels_in;
         three_ch_ff <= three_ch_in;
      end
   end

   assign cfg.image_width        = width_ff;
   assign cfg.image_height       = height_ff;
   assign cfg.level_count        = levels_ff;
   assign cfg.three_channel_mode = three_ch_ff;
   assign cfg.restart            = restart;

endmodule

// ===== hdl/mbf_seq.sv =====
`timescale 1ns / 1ps

module mbf_seq #(
   parameter int MAX_WIDTH  = mbf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = mbf_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_LEVELS = mbf_pkg::MAX_LEVELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  mbf_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  mbf_pkg::req_type  req_data,
   input  logic              slot_free,
   output logic              ld_valid,
   output mbf_pkg::rsp_type  ld_data
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int KW = $clog2(MAX_LEVELS);
   localparam int LW = $clog2(MAX_LEVELS + 1);
   localparam int SW = KW + 1;
   localparam int BW = mbf_pkg::BLOCK_W;
   localparam int PW = mbf_pkg::PAIR_W;

   // clamped configuration
   logic [WW-1:0] w;
   logic [HW-1:0] h;
   logic [LW-1:0] lc;

   // level-0 raster position
   logic [XW-1:0] col0_ff, col0_in;
   logic [YW-1:0] row0_ff, row0_in;
   logic          wrap;
   logic [XW-1:0] c_acc;
   logic [YW-1:0] r_acc;
   logic          last_acc;
   logic [WW-1:0] c_next;
   logic          accept;
   mbf_pkg::pixel_type in_px;

   // pixel being worked on and its level
   mbf_pkg::seq_state_type state_ff, state_in;
   logic [KW-1:0]      lvl_ff, lvl_in;
   logic [XW-1:0]      col_ff, col_in;
   logic [YW-1:0]      row_ff, row_in;
   logic [XW-1:0]      off_ff, off_in;
   logic [XW-1:0]      idx_ff, idx_in;
   mbf_pkg::pixel_type px_ff, px_in;
   logic               last_ff, last_in;

   logic [SW-1:0] cur_sh, nxt_sh;
   logic [XW-1:0] tw_cur;
   logic          ok_in;
   logic          emit_in;

   // memories and their read registers
   mbf_pkg::block_type pend_mem [MAX_LEVELS];
   mbf_pkg::pair_type  prs_mem  [MAX_WIDTH];
   mbf_pkg::block_type pend_rd_ff;
   mbf_pkg::pair_type  prs_rd_ff;

   mbf_pkg::block_type sum_blk, left_blk, pend_wr;
   mbf_pkg::pair_type  pair_wr;
   mbf_pkg::pixel_type avg;

   logic rd_en, pend_we, prs_we;

   always_comb begin
      if (cfg.image_width == '0) w = WW'(1);
      else if (int'(cfg.image_width) > MAX_WIDTH) w = WW'(MAX_WIDTH);
      else w = WW'(cfg.image_width);
      if (cfg.image_height == '0) h = HW'(1);
      else if (int'(cfg.image_height) > MAX_HEIGHT) h = HW'(MAX_HEIGHT);
      else h = HW'(cfg.image_height);
      if (cfg.level_count == '0) lc = LW'(1);
      else if (int'(cfg.level_count) > MAX_LEVELS) lc = LW'(MAX_LEVELS);
      else lc = LW'(cfg.level_count);
   end

   assign accept = req_valid && req_ready;

   always_comb begin
      in_px[0] = req_data.red_in;
      in_px[1] = req_data.green_in;
      in_px[2] = req_data.blue_in;
      in_px[3] = cfg.three_channel_mode ? mbf_pkg::ALPHA_OPAQUE : req_data.alpha_in;
   end

   always_comb begin
      wrap     = (WW'(col0_ff) >= w) || (HW'(row0_ff) >= h);
      c_acc    = wrap ? '0 : col0_ff;
      r_acc    = wrap ? '0 : row0_ff;
      last_acc = (WW'(c_acc) == w - WW'(1)) && (HW'(r_acc) == h - HW'(1));
      c_next   = WW'(c_acc) + WW'(1);
      col0_in  = col0_ff;
      row0_in  = row0_ff;
      if (cfg.restart) begin
         col0_in = '0;
         row0_in = '0;
      end else if (accept) begin
         if (last_acc) begin
            col0_in = '0;
            row0_in = '0;
         end else if (c_next >= w) begin
            col0_in = '0;
            row0_in = r_acc + YW'(1);
         end else begin
            col0_in = XW'(c_next);
         end
      end
   end

   // block sums for the current level
   always_comb begin
      for (int ch = 0; ch < mbf_pkg::NUM_CH; ch++) begin
         sum_blk[ch]  = pend_rd_ff[ch] + BW'(px_ff[ch]);
         left_blk[ch] = BW'(prs_rd_ff[ch]) + BW'(px_ff[ch]);
         pend_wr[ch]  = row_ff[0] ? left_blk[ch] : BW'(px_ff[ch]);
         pair_wr[ch]  = sum_blk[ch][PW-1:0];
         avg[ch]      = sum_blk[ch][BW-1:2];
      end
   end

   // next pixel to present: the new level-0 beat when idle, else the parent level
   always_comb begin
      cur_sh = SW'(lvl_ff) + SW'(1);
      tw_cur = XW'(w >> cur_sh);
      if (state_ff == mbf_pkg::SEQ_IDLE) begin
         lvl_in  = '0;
         col_in  = c_acc;
         row_in  = r_acc;
         off_in  = '0;
         px_in   = in_px;
         last_in = last_acc;
      end else begin
         lvl_in  = lvl_ff + KW'(1);
         col_in  = col_ff >> 1;
         row_in  = row_ff >> 1;
         off_in  = off_ff + tw_cur;
         px_in   = avg;
         last_in = last_ff;
      end
      nxt_sh  = SW'(lvl_in) + SW'(1);
      ok_in   = (LW'(lvl_in) + LW'(1) < lc)
              && (WW'(col_in >> 1) < (w >> nxt_sh))
              && (HW'(row_in >> 1) < (h >> nxt_sh));
      emit_in = ok_in && col_in[0] && row_in[0];
      idx_in  = off_in + XW'(col_in >> 1);
   end

   always_comb begin
      ld_data.level        = 4'(lvl_in);
      ld_data.col          = 10'(col_in);
      ld_data.row          = 10'(row_in);
      ld_data.red_out      = px_in[0];
      ld_data.green_out    = px_in[1];
      ld_data.blue_out     = px_in[2];
      ld_data.alpha_out    = px_in[3];
      ld_data.last_of_item = !emit_in;
      ld_data.image_done   = !emit_in && last_in;
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      ld_valid  = 1'b0;
      pend_we   = 1'b0;
      prs_we    = 1'b0;
      unique case (state_ff)
         mbf_pkg::SEQ_IDLE: begin
            req_ready = slot_free;
            ld_valid  = req_valid && slot_free;
         end
         mbf_pkg::SEQ_EXEC: begin
            if (col_ff[0] && row_ff[0]) begin
               ld_valid = slot_free;
            end else begin
               pend_we = !col_ff[0];
               prs_we  = col_ff[0];
            end
         end
         default: ;
      endcase
   end

   assign rd_en = ld_valid && ok_in;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbf_pkg::SEQ_IDLE: begin
            if (req_valid && slot_free)
               state_in = ok_in ? mbf_pkg::SEQ_EXEC : mbf_pkg::SEQ_IDLE;
         end
         mbf_pkg::SEQ_EXEC: begin
            if (col_ff[0] && row_ff[0]) begin
               if (slot_free)
                  state_in = ok_in ? mbf_pkg::SEQ_EXEC : mbf_pkg::SEQ_IDLE;
            end else begin
               state_in = mbf_pkg::SEQ_IDLE;
            end
         end
         default: state_in = mbf_pkg::SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbf_pkg::SEQ_IDLE;
         col0_ff  <= '0;
         row0_ff  <= '0;
      end else begin
         state_ff <= state_in;
         col0_ff  <= col0_in;
         row0_ff  <= row0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_valid) begin
         lvl_ff  <= lvl_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         off_ff  <= off_in;
         idx_ff  <= idx_in;
         px_ff   <= px_in;
         last_ff <= last_in;
      end
   end

   // reads happen on a load, writes only in a terminating step: never both in one cycle
   always_ff @(posedge clock) begin
      if (pend_we) pend_mem[lvl_ff] <= pend_wr;
      if (prs_we)  prs_mem[idx_ff]  <= pair_wr;
      if (rd_en) begin
         pend_rd_ff <= pend_mem[lvl_in];
         prs_rd_ff  <= prs_mem[idx_in];
      end
   end

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(pend_we && prs_we))
      else $error("both memories written in one cycle");

   a_no_rd_wr: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && (pend_we || prs_we)))
      else $error("memory read overlaps a write-back");

   a_cascade: assert property (@(posedge clock) disable iff (reset)
      ld_valid && !ld_data.last_of_item |=> state_ff == mbf_pkg::SEQ_EXEC)
      else $error("result not marked last but sequencer stopped");

   a_write_ends: assert property (@(posedge clock) disable iff (reset)
      (pend_we || prs_we) |=> state_ff == mbf_pkg::SEQ_IDLE)
      else $error("sequencer kept working after write-back");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      ld_valid && ld_data.image_done |=> col0_ff == '0 && row0_ff == '0)
      else $error("raster position not cleared at end of image");

endmodule

// ===== hdl/mbf_rsp.sv =====
`timescale 1ns / 1ps

module mbf_rsp (
   input  logic              clock,
   input  logic              reset,
   input  logic              ld_valid,
   input  mbf_pkg::rsp_type  ld_data,
   output logic              slot_free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mbf_pkg::rsp_type  rsp_data
);

   logic             valid_ff, valid_in;
   mbf_pkg::rsp_type data_ff;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (ld_valid) valid_in = 1'b1;
      else if (rsp_ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   // hold the beat until taken
   always_ff @(posedge clock) begin
      if (ld_valid) data_ff <= ld_data;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== hdl/mipmap_box_filter_chain.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_data  (level-0 RGBA pixel)
// rsp       out        rsp_valid/rsp_ready    rsp_data  (level, col, row, RGBA, flags)
// csr       in         csr_valid/csr_ready    csr_index, csr_data (register write)
//
// A pixel that touches no higher level ends with its level-0 result. Otherwise the
// sequencer goes on to emit each higher-level pixel it completes (up to MAX_LEVELS
// results) and ends when no further level applies or in a block-sum or row-sum write-back.
// The block-sum and row-sum memories are read into registers when a result is loaded.
// Reset is synchronous; it clears the raster position and the sequencer. The memories are
// not cleared: every entry is written before it is read.
// rsp_ready low holds the result register, and with it the sequencer and req_ready.
// csr_ready is always high; any listed register write restarts the image at (0,0).

module mipmap_box_filter_chain #(
   parameter int MAX_WIDTH  = mbf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = mbf_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_LEVELS = mbf_pkg::MAX_LEVELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  mbf_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output mbf_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mbf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mbf_pkg::CSR_DATA_W-1:0]  csr_data
);

   mbf_pkg::cfg_type cfg;
   logic             slot_free;
   logic             ld_valid;
   mbf_pkg::rsp_type ld_data;

   mbf_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mbf_seq #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_LEVELS (MAX_LEVELS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .slot_free (slot_free),
      .ld_valid  (ld_valid),
      .ld_data   (ld_data)
   );

   mbf_rsp u_rsp (
      .clock     (clock),
      .reset     (reset),
      .ld_valid  (ld_valid),
      .ld_data   (ld_data),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import mbf_pkg::*;

   localparam int IDLE_PCT      = 24;
   localparam int SETTLE_CYCLES = 16;
   localparam int STALL_LIMIT   = 2000;
   localparam int TOTAL_ITEMS   = 350;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = CSR_INDEX_W'(CSR_THREE_CHANNEL + 1);

   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_PIX,
      ROW_ECHO
   } plan_kind_type;

   typedef struct packed {
      plan_kind_type          kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  value;
      req_type                pix;
      rsp_type                echo;
   } plan_row_type;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // shadow of the block: registers, raster position and filter memories
   logic [10:0]       cfg_width  = WIDTH_RST;
   logic [10:0]       cfg_height = HEIGHT_RST;
   logic [3:0]        cfg_levels = LEVELS_RST;
   logic              cfg_rgb    = 1'b0;
   int unsigned       next_col   = 0;
   int unsigned       next_row   = 0;
   logic [0:3][8:0]   row_pair  [0:MAX_WIDTH_DEF-1];
   logic [0:3][9:0]   block_sum [0:MAX_LEVELS_DEF-1];
   rsp_type           mip_burst [0:MAX_LEVELS_DEF-1];

   rsp_type      mip_pixels_due [$];
   plan_row_type plan [$];
   rsp_type      due;
   int           items_sent   = 0;
   int           mismatches   = 0;
   int           stall_cycles = 0;

   wire steady = (items_sent >= 150) && (items_sent < 230);

   mipmap_box_filter_chain u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      return (v == 0) ? 1 : ((v > hi) ? hi : v);
   endfunction

   function automatic rsp_type make_rsp(input int unsigned lvl, input int unsigned c,
                                        input int unsigned r, input logic [0:3][7:0] px);
      rsp_type o;
      o.level        = 4'(lvl);
      o.col          = 10'(c);
      o.row          = 10'(r);
      o.red_out      = px[0];
      o.green_out    = px[1];
      o.blue_out     = px[2];
      o.alpha_out    = px[3];
      o.last_of_item = 1'b0;
      o.image_done   = 1'b0;
      return o;
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_W-1:0] index,
                                     input logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_IMAGE_WIDTH:   cfg_width  = value;
         CSR_IMAGE_HEIGHT:  cfg_height = value;
         CSR_LEVEL_COUNT:   cfg_levels = value[3:0];
         CSR_THREE_CHANNEL: cfg_rgb    = value[0];
         default:           return;
      endcase
      next_col = 0;
      next_row = 0;
   endfunction

   // Fill mip_burst with the results of one level-0 pixel; return how many.
   function automatic int filter_pixel(input req_type pix);
      int unsigned     w, h, lc, c, r, hc, hr, tw, th, idx, off;
      logic [0:3][7:0] px;
      logic [0:3][9:0] acc;
      int              n;
      bit              at_end;
      w  = clamp_dim(cfg_width, MAX_WIDTH_DEF);
      h  = clamp_dim(cfg_height, MAX_HEIGHT_DEF);
      lc = clamp_dim(cfg_levels, MAX_LEVELS_DEF);
      px = {pix.red_in, pix.green_in, pix.blue_in, cfg_rgb ? ALPHA_OPAQUE : pix.alpha_in};
      c  = next_col;
      r  = next_row;
      if (c >= w || r >= h) begin
         c = 0;
         r = 0;
      end
      at_end = (c == w - 1) && (r == h - 1);
      mip_burst[0] = make_rsp(0, c, r, px);
      n = 1;
      if (c + 1 >= w) begin
         next_col = 0;
         next_row = r + 1;
      end else begin
         next_col = c + 1;
         next_row = r;
      end
      off = 0;
      for (int k = 0; k + 1 < lc && k + 1 < MAX_LEVELS_DEF; k++) begin
         tw  = w >> (k + 1);
         th  = h >> (k + 1);
         hc  = c >> 1;
         hr  = r >> 1;
         idx = off + hc;
         off += tw;
         if (hc >= tw || hr >= th || idx >= MAX_WIDTH_DEF)
            break;
         // even column opens a block: seed it from this pixel or the stored pair
         if (c % 2 == 0) begin
            for (int ch = 0; ch < NUM_CH; ch++)
               block_sum[k][ch] = (r % 2 == 0) ? 10'(px[ch])
                                               : 10'(row_pair[idx][ch]) + 10'(px[ch]);
            break;
         end
         for (int ch = 0; ch < NUM_CH; ch++)
            acc[ch] = block_sum[k][ch] + 10'(px[ch]);
         if (r % 2 == 0) begin
            for (int ch = 0; ch < NUM_CH; ch++)
               row_pair[idx][ch] = acc[ch][8:0];
            break;
         end
         for (int ch = 0; ch < NUM_CH; ch++)
            px[ch] = acc[ch][9:2];
         mip_burst[n] = make_rsp(k + 1, hc, hr, px);
         n++;
         c = hc;
         r = hr;
      end
      mip_burst[n-1].last_of_item = 1'b1;
      if (at_end) begin
         mip_burst[n-1].image_done = 1'b1;
         next_col = 0;
         next_row = 0;
      end
      return n;
   endfunction

   function automatic logic [10:0] pick_dim();
      case ($urandom_range(11))
         0:       return 11'd0;
         1:       return 11'd2047;
         2:       return 11'd1024;
         3:       return 11'($urandom_range(2046, 1025));
         4, 5:    return 11'd1 << $urandom_range(3, 1);
         default: return 11'($urandom_range(9, 1));
      endcase
   endfunction

   function automatic void add_csr(input logic [CSR_INDEX_W-1:0] index,
                                   input logic [CSR_DATA_W-1:0] value);
      plan_row_type row;
      row       = '0;
      row.kind  = ROW_CSR;
      row.index = index;
      row.value = value;
      plan.push_back(row);
   endfunction

   function automatic void add_pix(input req_type pix);
      plan_row_type row;
      row      = '0;
      row.kind = ROW_PIX;
      row.pix  = pix;
      plan.push_back(row);
   endfunction

   // level-0 echo whose result is known by hand
   function automatic void add_echo(input req_type pix, input int unsigned c, input int unsigned r,
                                    input logic [7:0] alpha, input logic done);
      plan_row_type row;
      row      = '0;
      row.kind = ROW_ECHO;
      row.pix  = pix;
      row.echo = make_rsp(0, c, r, {pix.red_in, pix.green_in, pix.blue_in, alpha});
      row.echo.last_of_item = 1'b1;
      row.echo.image_done   = done;
      plan.push_back(row);
   endfunction

   // drop valid, wait for every due pixel, then let write-back finish
   task automatic settle();
      req_valid <= 1'b0;
      while (mip_pixels_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_reg(index, value);
   endtask

   task automatic send_pixel(input req_type pix, input bit by_hand, input rsp_type echo);
      int gap;
      int n;
      gap = 0;
      while (!steady && $urandom_range(99) < IDLE_PCT)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pix;
      do @(posedge clock); while (!req_ready);
      n = filter_pixel(pix);
      if (by_hand)
         mip_pixels_due.push_back(echo);
      else
         for (int i = 0; i < n; i++)
            mip_pixels_due.push_back(mip_burst[i]);
      items_sent++;
   endtask

   always @(posedge clock)
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) begin
         if (mip_pixels_due.size() == 0) begin
            mismatches++;
            $display("%0t unexpected beat: expected none, got lvl %0d (%0d,%0d) rgba %h last %b done %b",
                     $time, rsp_data.level, rsp_data.col, rsp_data.row,
                     {rsp_data.red_out, rsp_data.green_out, rsp_data.blue_out, rsp_data.alpha_out},
                     rsp_data.last_of_item, rsp_data.image_done);
         end else begin
            due = mip_pixels_due.pop_front();
            if (rsp_data !== due) begin
               mismatches++;
               $display("%0t mismatch: expected lvl %0d (%0d,%0d) rgba %h last %b done %b",
                        $time, due.level, due.col, due.row,
                        {due.red_out, due.green_out, due.blue_out, due.alpha_out},
                        due.last_of_item, due.image_done);
               $display("%0t            got lvl %0d (%0d,%0d) rgba %h last %b done %b",
                        $time, rsp_data.level, rsp_data.col, rsp_data.row,
                        {rsp_data.red_out, rsp_data.green_out, rsp_data.blue_out,
                         rsp_data.alpha_out},
                        rsp_data.last_of_item, rsp_data.image_done);
            end
         end
      end

   always @(posedge clock)
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t no beat for %0d cycles", $time, stall_cycles);
         $display("status: fail");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;

   initial begin : stimulus
      int unsigned area;
      int unsigned n;

      // after reset: 1024x1024, eleven levels, RGBA
      add_echo(32'h10203040, 0, 0, 8'h40, 1'b0);
      add_echo(32'hFFFFFFFF, 1, 0, 8'hFF, 1'b0);
      add_echo(32'h00000000, 2, 0, 8'h00, 1'b0);
      // three-channel mode restarts the image and forces alpha
      add_csr(CSR_THREE_CHANNEL, 11'd1);
      add_echo(32'h0A0B0C12, 0, 0, 8'hFF, 1'b0);
      // zero size acts as 1x1: every pixel ends the image
      add_csr(CSR_IMAGE_WIDTH, 11'd0);
      add_csr(CSR_IMAGE_HEIGHT, 11'd0);
      add_echo(32'h01020304, 0, 0, 8'hFF, 1'b1);
      add_echo(32'hFEDCBA98, 0, 0, 8'hFF, 1'b1);
      // 2x2 with two levels, then a pixel past the end of the image
      add_csr(CSR_IMAGE_WIDTH, 11'd2);
      add_csr(CSR_IMAGE_HEIGHT, 11'd2);
      add_csr(CSR_LEVEL_COUNT, 11'd2);
      add_pix(32'hFFFFFFFF);
      add_pix(32'h80808080);
      add_pix(32'h01010101);
      add_pix(32'h7F7F7F7F);
      add_echo(32'h11223344, 0, 0, 8'hFF, 1'b0);
      // oversize width saturates, zero level count acts as one level
      add_csr(CSR_THREE_CHANNEL, 11'd0);
      add_csr(CSR_IMAGE_WIDTH, 11'd2047);
      add_csr(CSR_IMAGE_HEIGHT, 11'd3);
      add_csr(CSR_LEVEL_COUNT, 11'd0);
      add_echo(32'h55667788, 0, 0, 8'h88, 1'b0);
      // a write outside the register list must not restart the image
      add_csr(CSR_SPARE_INDEX, 11'h7FF);
      add_echo(32'h99AABBCC, 1, 0, 8'hCC, 1'b0);
      // odd width drops the last column; level count above the limit saturates
      add_csr(CSR_IMAGE_WIDTH, 11'd3);
      add_csr(CSR_IMAGE_HEIGHT, 11'd2);
      add_csr(CSR_LEVEL_COUNT, 11'd15);
      add_pix(32'h20406080);
      add_pix(32'hFF00FF00);
      add_pix(32'h13579BDF);
      add_pix(32'h00FF00FF);
      add_pix(32'hFEFDFCFB);
      add_pix(32'h02468ACE);
      // one column, full height
      add_csr(CSR_IMAGE_WIDTH, 11'd1);
      add_csr(CSR_IMAGE_HEIGHT, 11'd1024);
      add_echo(32'h0F0F0F0F, 0, 0, 8'h0F, 1'b0);
      add_echo(32'hF0F0F0F0, 0, 1, 8'hF0, 1'b0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i])
         case (plan[i].kind)
            ROW_CSR:  write_reg(plan[i].index, plan[i].value);
            ROW_PIX:  send_pixel(plan[i].pix, 1'b0, '0);
            ROW_ECHO: send_pixel(plan[i].pix, 1'b1, plan[i].echo);
            default:  ;
         endcase

      while (items_sent < TOTAL_ITEMS) begin
         if ($urandom_range(3) != 0)
            write_reg(CSR_IMAGE_WIDTH, pick_dim());
         if ($urandom_range(3) != 0)
            write_reg(CSR_IMAGE_HEIGHT, pick_dim());
         if ($urandom_range(1) == 0)
            write_reg(CSR_LEVEL_COUNT,
                      {7'($urandom), ($urandom_range(1) ? LEVELS_RST : 4'($urandom))});
         if ($urandom_range(1) == 0)
            write_reg(CSR_THREE_CHANNEL, 11'($urandom));
         if ($urandom_range(9) == 0)
            write_reg(8'($urandom_range(255, CSR_SPARE_INDEX)), 11'($urandom));
         area = clamp_dim(cfg_width, MAX_WIDTH_DEF) * clamp_dim(cfg_height, MAX_HEIGHT_DEF);
         // whole images where they are small, a slice of the raster otherwise
         if (area > 81)
            n = $urandom_range(30, 3);
         else
            case ($urandom_range(5))
               0:       n = $urandom_range(area, 1);
               1:       n = 2 * area;
               2:       n = area + $urandom_range(area, 1);
               default: n = area;
            endcase
         // stop at the item budget
         if (items_sent + int'(n) > TOTAL_ITEMS)
            n = $unsigned(TOTAL_ITEMS - items_sent);
         repeat (n) begin
            if ($urandom_range(29) == 0)
               settle();
            send_pixel(req_type'($urandom), 1'b0, '0);
         end
      end

      settle();
      if (mismatches == 0 && mip_pixels_due.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
